>>> sv/rec_pkg.sv
`default_nettype none

package rec_pkg;

  // Header layout, in bytes from the start of the buffer
  localparam int unsigned HDR_BYTES     = 124;
  localparam int unsigned MAGIC_LAST    = 3;
  localparam int unsigned VERSION_LAST  = 7;
  localparam int unsigned LEN_FIRST     = 108;
  localparam int unsigned LEN_LAST      = 115;
  localparam int unsigned HCHK_LAST     = 119;
  localparam int unsigned PCHK_LAST     = 123;
  localparam int unsigned POS_W         = 7;

  localparam int unsigned OFFSET_WIDTH_DEF = 32;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

  // Register reset values
  localparam logic [31:0] MAGIC_RESET   = 32'h4B53_4645;
  localparam logic [31:0] VERSION_RESET = 32'h0000_0001;
  localparam logic [31:0] LIMIT_RESET   = 32'h0010_0000;

  // Register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

  typedef enum logic [1:0] {
    REGION_HEADER   = 2'd0,
    REGION_PAYLOAD  = 2'd1,
    REGION_TRAILING = 2'd2
  } region_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_TOO_LONG    = 3'd4,
    ST_HEADER_CRC  = 3'd5,
    ST_PAYLOAD_CRC = 3'd6
  } status_e;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> sv/rec_out_buf.sv
`default_nettype none

// Output register with a skid stage: the upstream side keeps flowing for
// one more word after the downstream side stalls.
module rec_out_buf #(
  parameter int unsigned W = 48
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [W-1:0] in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [W-1:0]      out_data_o
);

  logic         out_valid_q;
  logic [W-1:0] out_data_q;
  logic         skid_valid_q;
  logic [W-1:0] skid_data_q;
  logic         push;
  logic         pop;

  assign in_ready_o  = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign push        = in_valid_i & ~skid_valid_q;
  assign pop         = out_valid_q & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid_q || pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      if (!out_valid_q || pop) begin
        out_data_q <= in_data_i;
      end else begin
        skid_data_q <= in_data_i;
      end
    end else if (pop && skid_valid_q) begin
      out_data_q <= skid_data_q;
    end
  end

  // Skid holds a word only while the output register is full
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");
  // A stalled output word does not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("output word changed under stall");
  // With the skid full, nothing more is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("skid word lost");

endmodule

`default_nettype wire

>>> sv/record_envelope_checker.sv
// Record envelope checker.
// Input stream s_axis carries one buffer byte per word; tlast marks the
// buffer's final byte, and the next word starts a new buffer.
// The first 124 bytes are a little-endian header (magic, version, 64-bit
// payload length, header CRC, payload CRC); the payload follows.
// Output stream m_axis gives one word per input word: the byte echoed with
// its region (header, payload, trailing), its saturating offset, and on
// exactly one word per buffer a verdict with a status code.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 magic, 1 version, 2 payload limit); other indexes are ignored.
// Write only while the stream is idle.
// Each byte's result is registered in the output register or skid stage;
// throughput: one byte per cycle while m_axis takes words. The CRC step and
// all compares sit in one combinational pass between input handshake and
// output register. Reset: stream state clears, registers take their reset
// values, m_axis is empty. tlast also returns the stream state to reset.
// Stall: an output register plus a skid stage let one more byte in after
// m_axis stalls; then s_axis_tready drops until the receiver takes a word.
`default_nettype none

module record_envelope_checker #(
  parameter int unsigned OFFSET_WIDTH = rec_pkg::OFFSET_WIDTH_DEF,
  localparam int unsigned OUT_BITS    = 14 + OFFSET_WIDTH,
  localparam int unsigned OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // data_byte [7:0]
  input  wire logic [7:0]                    s_axis_tdata,
  input  wire logic                          s_axis_tlast,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // echo_byte, region, byte_offset, verdict_valid, status, zero fill
  output logic [OUT_W-1:0]                   m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic                          cfg_we_i,
  input  wire logic [rec_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]                   cfg_data_i
);

  localparam int unsigned VV_BIT  = 10 + OFFSET_WIDTH;
  localparam int unsigned ST_LSB  = 11 + OFFSET_WIDTH;

  // Configuration registers
  logic [31:0] magic_q;
  logic [31:0] version_q;
  logic [31:0] limit_q;

  // Stream state
  logic [rec_pkg::POS_W-1:0] pos_q;
  logic [31:0]               pay_off_q;
  logic [31:0]               hcrc_q;
  logic [31:0]               pcrc_q;
  logic [31:0]               word_q;
  logic [63:0]               len_q;
  logic [31:0]               pchk_q;
  logic                      done_q;

  logic                      accept;
  logic                      in_hdr;
  logic [31:0]               word_d;
  logic [63:0]               len_d;
  logic [31:0]               hcrc_d;
  logic [31:0]               pcrc_d;
  logic                      dec;
  rec_pkg::status_e          status;
  rec_pkg::region_e          region;
  logic [OFFSET_WIDTH-1:0]   offset;
  logic                      verdict;
  logic [OUT_W-1:0]          res_data;

  assign accept = s_axis_tvalid & s_axis_tready;
  assign in_hdr = (pos_q < rec_pkg::POS_W'(rec_pkg::HDR_BYTES));

  assign word_d = {s_axis_tdata, word_q[31:8]};
  assign len_d  = {s_axis_tdata, len_q[63:8]};
  assign hcrc_d = rec_pkg::crc_byte(hcrc_q, s_axis_tdata);
  assign pcrc_d = rec_pkg::crc_byte(pcrc_q, s_axis_tdata);

  // Decide the verdict of this byte; the check of a deciding byte wins
  // over too_short on the buffer's last byte.
  always_comb begin
    dec    = 1'b0;
    status = rec_pkg::ST_OK;
    if (in_hdr) begin
      if (pos_q == rec_pkg::POS_W'(rec_pkg::MAGIC_LAST)) begin
        if (word_d != magic_q) begin
          dec    = 1'b1;
          status = rec_pkg::ST_BAD_MAGIC;
        end
      end else if (pos_q == rec_pkg::POS_W'(rec_pkg::VERSION_LAST)) begin
        if (word_d != version_q) begin
          dec    = 1'b1;
          status = rec_pkg::ST_BAD_VERSION;
        end
      end else if (pos_q == rec_pkg::POS_W'(rec_pkg::LEN_LAST)) begin
        if (len_d > {32'h0, limit_q}) begin
          dec    = 1'b1;
          status = rec_pkg::ST_TOO_LONG;
        end
      end else if (pos_q == rec_pkg::POS_W'(rec_pkg::HCHK_LAST)) begin
        if ((hcrc_q ^ rec_pkg::ALL_ONES) != word_d) begin
          dec    = 1'b1;
          status = rec_pkg::ST_HEADER_CRC;
        end
      end else if (pos_q == rec_pkg::POS_W'(rec_pkg::PCHK_LAST)) begin
        if (len_q == 64'h0) begin
          dec = 1'b1;
        end
      end
    end else begin
      // Length passed the limit check, so it fits in 32 bits here
      if ((33'(pay_off_q) + 33'd1) == {1'b0, len_q[31:0]}) begin
        dec    = 1'b1;
        status = ((pcrc_d ^ rec_pkg::ALL_ONES) == pchk_q) ? rec_pkg::ST_OK
                                                          : rec_pkg::ST_PAYLOAD_CRC;
      end
    end
    if (!dec && s_axis_tlast) begin
      dec    = 1'b1;
      status = rec_pkg::ST_TOO_SHORT;
    end
  end

  // Region and saturating offset of this byte
  always_comb begin
    verdict = 1'b0;
    region  = rec_pkg::REGION_TRAILING;
    offset  = '0;
    if (!done_q) begin
      verdict = dec;
      if (in_hdr) begin
        region = rec_pkg::REGION_HEADER;
        offset = OFFSET_WIDTH'(pos_q);
      end else begin
        region = rec_pkg::REGION_PAYLOAD;
        if ((pay_off_q >> OFFSET_WIDTH) != 32'h0) begin
          offset = '1;
        end else begin
          offset = OFFSET_WIDTH'(pay_off_q);
        end
      end
    end
  end

  assign res_data = OUT_W'({(verdict ? status : rec_pkg::ST_OK), verdict, offset,
                            region, s_axis_tdata});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= rec_pkg::MAGIC_RESET;
      version_q <= rec_pkg::VERSION_RESET;
      limit_q   <= rec_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rec_pkg::CFG_MAGIC:   magic_q   <= cfg_data_i;
        rec_pkg::CFG_VERSION: version_q <= cfg_data_i;
        rec_pkg::CFG_LIMIT:   limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      pay_off_q <= '0;
      hcrc_q    <= rec_pkg::ALL_ONES;
      pcrc_q    <= rec_pkg::ALL_ONES;
      word_q    <= '0;
      len_q     <= '0;
      pchk_q    <= '0;
      done_q    <= 1'b0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        // End of buffer: drop all stream state
        pos_q     <= '0;
        pay_off_q <= '0;
        hcrc_q    <= rec_pkg::ALL_ONES;
        pcrc_q    <= rec_pkg::ALL_ONES;
        word_q    <= '0;
        len_q     <= '0;
        pchk_q    <= '0;
        done_q    <= 1'b0;
      end else if (!done_q) begin
        done_q <= dec;
        if (in_hdr) begin
          pos_q  <= pos_q + rec_pkg::POS_W'(1);
          word_q <= word_d;
          if (pos_q <= rec_pkg::POS_W'(rec_pkg::LEN_LAST)) begin
            hcrc_q <= hcrc_d;
          end
          if (pos_q >= rec_pkg::POS_W'(rec_pkg::LEN_FIRST) &&
              pos_q <= rec_pkg::POS_W'(rec_pkg::LEN_LAST)) begin
            len_q <= len_d;
          end
          if (pos_q == rec_pkg::POS_W'(rec_pkg::PCHK_LAST)) begin
            pchk_q <= word_d;
          end
        end else begin
          pay_off_q <= pay_off_q + 32'd1;
          pcrc_q    <= pcrc_d;
        end
      end
    end
  end

  rec_out_buf #(
    .W (OUT_W)
  ) u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // A verdict word never lies in the trailing region
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[VV_BIT]) |->
    (m_axis_tdata[9:8] != rec_pkg::REGION_TRAILING))
    else $error("verdict on a trailing byte");
  // A nonzero status only rides on a verdict word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[ST_LSB +: 3] != rec_pkg::ST_OK)) |->
    m_axis_tdata[VV_BIT])
    else $error("status without verdict");
  // A verdict without end of buffer leaves the stream in trailing mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && verdict && !s_axis_tlast) |=> done_q)
    else $error("verdict not recorded");
  // End of buffer returns to the first header byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (pos_q == '0 && !done_q && pay_off_q == 32'h0))
    else $error("stream state not cleared at end of buffer");

endmodule

`default_nettype wire
